// ===== src/first_fit_free_list_allocator_macros.svh =====
// assertion macros for the first-fit free-list allocator
// used by the top level only, no other dependencies
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");
// next-cycle implication
`define FFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define FFA_ASSERT_NOW(label, ante, cons)
`define FFA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/ffa_pkg.sv =====
// shared types and constants of the first-fit free-list allocator
// no dependencies
package ffa_pkg;

    localparam int HEAP_UNITS_DEF = 65536;
    localparam int UNIT_BYTES_DEF = 16;
    localparam int BYTES_W        = 21;
    localparam int NEED_W         = 22;   // bytes plus rounding, quotient width
    localparam int IDX_OUT_W      = 16;
    localparam int SPLIT_MIN      = 2;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NO_FIT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_ZERO  = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [NEED_W-1:0]      need;
        logic [IDX_OUT_W-1:0]   rel;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== src/ffa_front.sv =====
// front end: accepts requests, rounds byte counts up to units with a reciprocal multiply
// depends on ffa_pkg
module ffa_front #(
    parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic                       action,
    input  logic [ffa_pkg::BYTES_W-1:0] request_bytes,
    input  logic [ffa_pkg::IDX_OUT_W-1:0] release_index,
    output logic                       q_push,
    output ffa_pkg::cmd_t              q_data,
    input  ffa_pkg::q_status_t         q_stat
);
    // exact floor division for any numerator below 2**NEED_W
    localparam int     SH     = ffa_pkg::NEED_W + $clog2(UNIT_BYTES);
    localparam int     PROD_W = SH + ffa_pkg::NEED_W;
    localparam longint RECIP  = ((longint'(1) << SH) + longint'(UNIT_BYTES) - 1)
                              / longint'(UNIT_BYTES);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } fstate_t;

    fstate_t                   state_reg, state_next;
    logic [ffa_pkg::NEED_W-1:0] num_reg, num_next;
    ffa_pkg::cmd_t             cmd_reg, cmd_next;
    logic [PROD_W-1:0]         prod;

    assign s_tready = (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_stat.full;
    assign q_data   = cmd_reg;

    // combinational multiply of the registered numerator by the scaled reciprocal of the unit size
    assign prod = PROD_W'(num_reg) * PROD_W'(RECIP);

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        cmd_next   = cmd_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next.rel  = release_index;
                    cmd_next.need = '0;
                    if (action)
                    begin
                        cmd_next.kind = ffa_pkg::CMD_FREE;
                        state_next    = F_PUSH;
                    end
                    else if (request_bytes == '0)
                    begin
                        cmd_next.kind = ffa_pkg::CMD_ZERO;
                        state_next    = F_PUSH;
                    end
                    else
                    begin
                        cmd_next.kind = ffa_pkg::CMD_ALLOC;
                        num_next = ffa_pkg::NEED_W'(request_bytes)
                                 + ffa_pkg::NEED_W'(UNIT_BYTES - 1);
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                cmd_next.need = prod[SH +: ffa_pkg::NEED_W];
                state_next    = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_stat.full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        cmd_reg <= cmd_next;
    end

endmodule

// ===== src/ffa_queue.sv =====
// two-entry command queue between front and back end
// depends on ffa_pkg
module ffa_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ffa_pkg::cmd_t      push_data,
    input  logic               pop,
    output ffa_pkg::cmd_t      pop_data,
    output ffa_pkg::q_status_t stat
);
    ffa_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== src/ffa_back.sv =====
// back end: header memories, first-fit list walk, split and unlink, result register
// depends on ffa_pkg
module ffa_back #(
    parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffa_pkg::cmd_t                 q_data,
    input  ffa_pkg::q_status_t            q_stat,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [1:0]                    status,
    output logic [ffa_pkg::IDX_OUT_W-1:0] granted_index,
    output logic [ffa_pkg::IDX_OUT_W-1:0] granted_units
);
    localparam int IDX_W  = $clog2(HEAP_UNITS);
    localparam int LINK_W = $clog2(HEAP_UNITS + 1);
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(HEAP_UNITS);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_READ = 5'b00010,
        B_EVAL = 5'b00100,
        B_LINK = 5'b01000,
        B_OUT  = 5'b10000
    } bstate_t;

    logic [IDX_W-1:0]  size_mem [HEAP_UNITS];
    logic [LINK_W-1:0] link_mem [HEAP_UNITS];

    bstate_t             state_reg, state_next;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [LINK_W-1:0]   cur_reg, cur_next;
    logic [LINK_W-1:0]   prev_reg, prev_next;
    logic [LINK_W-1:0]   repl_reg, repl_next;
    logic [LINK_W-1:0]   vis_reg, vis_next;
    logic [ffa_pkg::NEED_W-1:0] need_reg, need_next;
    logic                split_reg, split_next;
    logic                size0_wr_reg, size0_wr_next;
    logic                link0_wr_reg, link0_wr_next;
    logic                rd_zero_reg;
    ffa_pkg::status_t    res_st_reg, res_st_next;
    logic [ffa_pkg::IDX_OUT_W-1:0] res_idx_reg, res_idx_next;
    logic [ffa_pkg::IDX_OUT_W-1:0] res_units_reg, res_units_next;
    logic                ovalid_reg, ovalid_next;
    logic [1:0]          ost_reg;
    logic [ffa_pkg::IDX_OUT_W-1:0] oidx_reg, ounits_reg;

    logic [IDX_W-1:0]  size_q, size_rd;
    logic [LINK_W-1:0] link_q, link_rd;
    logic              size_we, link_we;
    logic [IDX_W-1:0]  size_wa, link_wa;
    logic [IDX_W-1:0]  size_wd;
    logic [LINK_W-1:0] link_wd;
    logic              rd_en, out_load;
    logic [31:0]       excess, rest, vis_inc;

    // entry 0 holds the whole heap until first written
    assign size_rd = (rd_zero_reg && !size0_wr_reg) ? IDX_W'(HEAP_UNITS - 1) : size_q;
    assign link_rd = (rd_zero_reg && !link0_wr_reg) ? LINK_END : link_q;

    assign rd_en    = (state_reg == B_READ);
    assign out_load = (state_reg == B_OUT) && (!ovalid_reg || m_tready);
    assign q_pop    = (state_reg == B_IDLE) && !q_stat.empty;

    assign excess  = 32'(size_rd) - 32'(need_reg);
    assign rest    = 32'(cur_reg) + 32'd1 + 32'(need_reg);
    assign vis_inc = 32'(vis_reg) + 32'd1;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        repl_next      = repl_reg;
        vis_next       = vis_reg;
        need_next      = need_reg;
        split_next     = split_reg;
        res_st_next    = res_st_reg;
        res_idx_next   = res_idx_reg;
        res_units_next = res_units_reg;
        size_we = 1'b0;
        size_wa = '0;
        size_wd = '0;
        link_we = 1'b0;
        link_wa = '0;
        link_wd = '0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    res_st_next    = ffa_pkg::ST_DONE;
                    res_idx_next   = '0;
                    res_units_next = '0;
                    need_next      = q_data.need;
                    unique case (q_data.kind)
                        ffa_pkg::CMD_ZERO:
                        begin
                            res_st_next = ffa_pkg::ST_ZERO;
                            state_next  = B_OUT;
                        end
                        ffa_pkg::CMD_FREE:
                        begin
                            // push onto the head, out-of-range indexes ignored
                            if (32'(q_data.rel) < 32'(HEAP_UNITS))
                            begin
                                link_we   = 1'b1;
                                link_wa   = IDX_W'(q_data.rel);
                                link_wd   = head_reg;
                                head_next = LINK_W'(q_data.rel);
                            end
                            state_next = B_OUT;
                        end
                        ffa_pkg::CMD_ALLOC:
                        begin
                            cur_next  = head_reg;
                            prev_next = LINK_END;
                            vis_next  = '0;
                            if (32'(head_reg) >= 32'(HEAP_UNITS))
                            begin
                                res_st_next = ffa_pkg::ST_NO_FIT;
                                state_next  = B_OUT;
                            end
                            else
                                state_next = B_READ;
                        end
                        default: state_next = B_OUT;
                    endcase
                end
            end
            B_READ:
            begin
                state_next = B_EVAL;
            end
            B_EVAL:
            begin
                if (32'(size_rd) >= 32'(need_reg))
                begin
                    split_next = (excess >= 32'(ffa_pkg::SPLIT_MIN))
                              && (rest < 32'(HEAP_UNITS));
                    if (split_next)
                    begin
                        // remainder gets its own header after the granted part
                        size_we   = 1'b1;
                        size_wa   = IDX_W'(rest);
                        size_wd   = IDX_W'(excess - 32'd1);
                        link_we   = 1'b1;
                        link_wa   = IDX_W'(rest);
                        link_wd   = link_rd;
                        repl_next = LINK_W'(rest);
                        res_units_next = ffa_pkg::IDX_OUT_W'(32'(need_reg));
                    end
                    else
                    begin
                        repl_next      = link_rd;
                        res_units_next = ffa_pkg::IDX_OUT_W'(32'(size_rd));
                    end
                    res_idx_next = ffa_pkg::IDX_OUT_W'(32'(cur_reg));
                    state_next   = B_LINK;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rd;
                    vis_next  = LINK_W'(vis_inc);
                    // end of list, or a cyclic list walked in full
                    if ((32'(link_rd) >= 32'(HEAP_UNITS)) || (vis_inc >= 32'(HEAP_UNITS)))
                    begin
                        res_st_next = ffa_pkg::ST_NO_FIT;
                        state_next  = B_OUT;
                    end
                    else
                        state_next = B_READ;
                end
            end
            B_LINK:
            begin
                if (split_reg)
                begin
                    size_we = 1'b1;
                    size_wa = IDX_W'(cur_reg);
                    size_wd = IDX_W'(need_reg);
                end
                if (32'(prev_reg) < 32'(HEAP_UNITS))
                begin
                    link_we = 1'b1;
                    link_wa = IDX_W'(prev_reg);
                    link_wd = repl_reg;
                end
                else
                    head_next = repl_reg;
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!ovalid_reg || m_tready)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        size0_wr_next = size0_wr_reg || (size_we && (size_wa == '0));
        link0_wr_next = link0_wr_reg || (link_we && (link_wa == '0));
        if (out_load)
            ovalid_next = 1'b1;
        else if (m_tready)
            ovalid_next = 1'b0;
        else
            ovalid_next = ovalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            head_reg     <= '0;
            size0_wr_reg <= 1'b0;
            link0_wr_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            size0_wr_reg <= size0_wr_next;
            link0_wr_reg <= link0_wr_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        repl_reg      <= repl_next;
        vis_reg       <= vis_next;
        need_reg      <= need_next;
        split_reg     <= split_next;
        res_st_reg    <= res_st_next;
        res_idx_reg   <= res_idx_next;
        res_units_reg <= res_units_next;
        if (out_load)
        begin
            ost_reg    <= res_st_reg;
            oidx_reg   <= res_idx_reg;
            ounits_reg <= res_units_reg;
        end
    end

    // header memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (size_we)
            size_mem[size_wa] <= size_wd;
        if (rd_en)
            size_q <= size_mem[cur_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa] <= link_wd;
        if (rd_en)
        begin
            link_q      <= link_mem[cur_reg[IDX_W-1:0]];
            rd_zero_reg <= (cur_reg == '0);
        end
    end

    assign m_tvalid      = ovalid_reg;
    assign status        = ost_reg;
    assign granted_index = oidx_reg;
    assign granted_units = ounits_reg;

endmodule

// ===== src/first_fit_free_list_allocator.sv =====
// top level of the first-fit free-list allocator: front end, command queue, back end
// depends on ffa_pkg, ffa_front, ffa_queue, ffa_back and the assertion macro header
`include "first_fit_free_list_allocator_macros.svh"

// first-fit heap allocator over HEAP_UNITS units of UNIT_BYTES bytes, no coalescing.
// each request (allocate or free) gives exactly one result. an allocate request is
// rounded up to whole units by a reciprocal multiply in the front end, so the front
// end steps through accept, multiply and push for an allocate and skips the multiply
// for a free or zero-size request; the push waits while the queue is full. the back
// end pops the queue, walks the free list from the head with a memory read then a
// compare per chunk visited, then splits/unlinks and hands the result to the output
// register, which waits while the previous result is not taken. a free, zero-size
// or empty-list request goes from the pop straight to the output register. an
// allocate walk in the back end overlaps the front end's work on the next request;
// the list length sets the rate. the header memories have no clearing pass: entry 0
// reads as the whole heap until first written.
module first_fit_free_list_allocator #(
    parameter int HEAP_UNITS = ffa_pkg::HEAP_UNITS_DEF,
    parameter int UNIT_BYTES = ffa_pkg::UNIT_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // request_bytes[20:0], release_index[36:21], zero fill
    input  logic [0:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // granted_index[15:0], granted_units[31:16]
    output logic [1:0]  m_tuser    // status
);
    ffa_pkg::cmd_t      q_in, q_out;
    ffa_pkg::q_status_t q_stat;
    logic               q_push, q_pop;
    logic [1:0]         status;
    logic [ffa_pkg::IDX_OUT_W-1:0] granted_index, granted_units;

    // request classification and unit rounding
    ffa_front #(
        .UNIT_BYTES(UNIT_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .action       (s_tuser[0]),
        .request_bytes(s_tdata[20:0]),
        .release_index(s_tdata[36:21]),
        .q_push       (q_push),
        .q_data       (q_in),
        .q_stat       (q_stat)
    );

    // decouples the rounding from the list walk
    ffa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_data(q_in),
        .pop      (q_pop),
        .pop_data (q_out),
        .stat     (q_stat)
    );

    // list walk, split and unlink, result register
    ffa_back #(
        .HEAP_UNITS(HEAP_UNITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_data       (q_out),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .status       (status),
        .granted_index(granted_index),
        .granted_units(granted_units)
    );

    assign m_tdata = {granted_units, granted_index};
    assign m_tuser = status;

    // a failed or zero-size request never carries a chunk
    `FFA_ASSERT_NOW(a_fail_zero_fields, m_tvalid && (m_tuser != ffa_pkg::ST_DONE), m_tdata == '0)
    // the queue cannot be both full and empty
    `FFA_ASSERT_NOW(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty))
    // the front end is busy in the cycle after it takes a request
    `FFA_ASSERT_NEXT(a_front_busy, s_tvalid && s_tready, !s_tready)
    // status never takes an undefined code
    `FFA_ASSERT_NOW(a_status_code, m_tvalid, m_tuser != 2'd3)

endmodule
